>>> rtl/dq_pkg.sv
// Shared types for the double-ended queue: opcodes, controller states and
// the command/status bundles between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned OCC_W   = 7;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_POP_BACK   = 3'd1,
    OP_PUSH_FRONT = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_DELETE     = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_DEL,
    S_RES
  } state_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic pop_load;
    logic del_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic pop_go;
    logic del_go;
    logic del_last;
  } status_t;

endpackage

`default_nettype wire

>>> rtl/dq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/dq_ctrl.sv
// Controller state machine for the double-ended queue.
// Depends on dq_pkg for states and the command/status bundles.
`timescale 1ns / 1ps
`default_nettype none

module dq_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  input  wire dq_pkg::status_t status_i,
  output dq_pkg::cmd_t      cmd_o
);

  dq_pkg::state_e state_q, state_d;
  logic           out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dq_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      dq_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = dq_pkg::S_EXEC;
        end
      end
      dq_pkg::S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (status_i.pop_go) begin
          state_d = dq_pkg::S_POP;
        end else if (status_i.del_go) begin
          state_d = dq_pkg::S_DEL;
        end else begin
          state_d = dq_pkg::S_RES;
        end
      end
      dq_pkg::S_POP: begin
        cmd_o.pop_load = 1'b1;
        state_d        = dq_pkg::S_RES;
      end
      dq_pkg::S_DEL: begin
        cmd_o.del_step = 1'b1;
        if (status_i.del_last) begin
          state_d = dq_pkg::S_RES;
        end
      end
      dq_pkg::S_RES: begin
        // hold the result until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = dq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = dq_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> rtl/dq_dp.sv
// Datapath for the double-ended queue: ring pointers, entry store, result
// and output registers. Depends on dq_pkg and dq_ram.
`timescale 1ns / 1ps
`default_nettype none

module dq_dp #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [dq_pkg::OP_W-1:0]     opcode_i,
  input  wire logic signed [dq_pkg::VALUE_W-1:0] value_i,
  input  wire dq_pkg::cmd_t                cmd_i,
  output dq_pkg::status_t                  status_o,
  output logic signed [dq_pkg::VALUE_W-1:0] popped_value_o,
  output logic                             was_empty_o,
  output logic                             was_full_o,
  output logic [dq_pkg::OCC_W-1:0]         occupancy_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [AW-1:0]         front_q, front_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         rd_idx_q, rd_idx_d;
  logic [CW-1:0]         kept_q, kept_d;
  dq_pkg::op_e           op_q, op_d;
  logic [DATA_WIDTH-1:0] word_q, word_d;
  logic [dq_pkg::VALUE_W-1:0] res_pop_q, res_pop_d;
  logic                  res_empty_q, res_empty_d;
  logic                  res_full_q, res_full_d;

  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  logic                  is_empty, is_full;

  function automatic logic [AW-1:0] ring(input logic [AW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + (AW+1)'(off);
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  dq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign is_empty = (count_q == '0);
  assign is_full  = (count_q >= CW'(DEPTH));

  always_comb begin
    status_o.pop_go   = !is_empty &&
                        (op_q == dq_pkg::OP_POP_BACK || op_q == dq_pkg::OP_POP_FRONT);
    status_o.del_go   = !is_empty && (op_q == dq_pkg::OP_DELETE);
    status_o.del_last = (rd_idx_q == count_q);
  end

  always_comb begin
    front_d     = front_q;
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    kept_d      = kept_q;
    op_d        = op_q;
    word_d      = word_q;
    res_pop_d   = res_pop_q;
    res_empty_d = res_empty_q;
    res_full_d  = res_full_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = word_q;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    if (cmd_i.capture) begin
      op_d   = dq_pkg::op_e'(opcode_i);
      word_d = DATA_WIDTH'(value_i);
    end

    if (cmd_i.exec) begin
      res_pop_d   = '0;
      res_empty_d = 1'b0;
      res_full_d  = 1'b0;
      case (op_q)
        dq_pkg::OP_PUSH_BACK: begin
          if (is_full) begin
            res_full_d = 1'b1;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = ring(front_q, count_q);
            count_d   = count_q + 1'b1;
          end
        end
        dq_pkg::OP_PUSH_FRONT: begin
          if (is_full) begin
            res_full_d = 1'b1;
          end else begin
            front_d   = (front_q == '0) ? AW'(DEPTH - 1) : front_q - 1'b1;
            ram_we    = 1'b1;
            ram_waddr = front_d;
            count_d   = count_q + 1'b1;
          end
        end
        dq_pkg::OP_POP_BACK: begin
          if (is_empty) begin
            res_empty_d = 1'b1;
            res_pop_d   = '1;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = ring(front_q, count_q - 1'b1);
            count_d   = count_q - 1'b1;
          end
        end
        dq_pkg::OP_POP_FRONT: begin
          if (is_empty) begin
            res_empty_d = 1'b1;
            res_pop_d   = '1;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = front_q;
            front_d   = ring(front_q, CW'(1));
            count_d   = count_q - 1'b1;
          end
        end
        dq_pkg::OP_DELETE: begin
          if (!is_empty) begin
            ram_re    = 1'b1;
            ram_raddr = front_q;
            rd_idx_d  = CW'(1);
            kept_d    = '0;
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.pop_load) begin
      res_pop_d = dq_pkg::VALUE_W'(signed'(ram_rdata));
    end

    if (cmd_i.del_step) begin
      // compact: keep entries that differ, advance the read ahead of the write
      if (ram_rdata != word_q) begin
        ram_we    = 1'b1;
        ram_waddr = ring(front_q, kept_q);
        ram_wdata = ram_rdata;
        kept_d    = kept_q + 1'b1;
      end
      if (rd_idx_q != count_q) begin
        ram_re    = 1'b1;
        ram_raddr = ring(front_q, rd_idx_q);
        rd_idx_d  = rd_idx_q + 1'b1;
      end else begin
        count_d = kept_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q    <= rd_idx_d;
    kept_q      <= kept_d;
    op_q        <= op_d;
    word_q      <= word_d;
    res_pop_q   <= res_pop_d;
    res_empty_q <= res_empty_d;
    res_full_q  <= res_full_d;
    if (cmd_i.load_out) begin
      popped_value_o <= res_pop_q;
      was_empty_o    <= res_empty_q;
      was_full_o     <= res_full_q;
      occupancy_o    <= dq_pkg::OCC_W'(count_q);
    end
  end

endmodule

`default_nettype wire

>>> rtl/double_ended_queue.sv
// Double-ended queue: push/pop at either end and delete-by-value with
// compaction, held in a ring RAM. Every request gives one result that
// carries the popped word, the empty-pop and full-push flags and the count
// of entries held afterwards. A push, a failed pop, a delete on an empty
// queue or an unused opcode goes from S_IDLE through S_EXEC to S_RES; a pop
// that finds an entry also passes S_POP, since the entry comes out of the
// registered RAM read. A delete walks the live entries in S_DEL through
// the single RAM read and write port, one entry a cycle. A finished result
// waits in the output register while the next request is taken; a result
// that finds that register still held waits for it, and input stays
// stalled meanwhile. Depends on dq_pkg, dq_ctrl, dq_dp and dq_ram.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [dq_pkg::OP_W-1:0]      opcode_i,
  input  wire logic signed [dq_pkg::VALUE_W-1:0] value_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic signed [dq_pkg::VALUE_W-1:0] popped_value_o,
  output logic                              was_empty_o,
  output logic                              was_full_o,
  output logic [dq_pkg::OCC_W-1:0]          occupancy_o
);

  dq_pkg::cmd_t    cmd;
  dq_pkg::status_t status;

  dq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  dq_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .opcode_i       (opcode_i),
    .value_i        (value_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .popped_value_o (popped_value_o),
    .was_empty_o    (was_empty_o),
    .was_full_o     (was_full_o),
    .occupancy_o    (occupancy_o)
  );

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request taken while a previous one is in progress");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(was_empty_o && was_full_o))
    else $error("empty and full flags both set");

  a_empty_pop_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && was_empty_o) |-> (popped_value_o == '1 && occupancy_o == '0))
    else $error("empty pop reports wrong value or count");

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking bench for double_ended_queue: random and directed push, pop and
// delete traffic with a built-in predictor of the ring and its count.
// Depends on dq_pkg and the double_ended_queue RTL.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned DQ_DEPTH       = 64;
  localparam int unsigned DQ_WIDTH       = 32;
  localparam int unsigned RANDOM_ITEMS   = 1500;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned HOLD_AT_RESULT = 200;
  localparam int unsigned SETTLE_CYCLES  = 2 * DQ_DEPTH + 16;
  localparam int unsigned RESET_CYCLES   = 8;

  typedef logic [dq_pkg::OP_W-1:0]           op_code_t;
  typedef logic signed [dq_pkg::VALUE_W-1:0] word_t;
  typedef logic [dq_pkg::OCC_W-1:0]          occ_t;

  localparam op_code_t OP_FIRST_UNUSED = op_code_t'(dq_pkg::OP_DELETE + 1);
  localparam op_code_t OP_LAST_UNUSED  = '1;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_e;

  typedef struct {
    op_code_t op;
    word_t    value;
    bit       pause;
  } request_t;

  typedef struct {
    word_t popped;
    logic  empty;
    logic  full;
    occ_t  occ;
  } dq_result_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  op_code_t opcode_i    = '0;
  word_t    value_i     = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  word_t    popped_value_o;
  logic     was_empty_o;
  logic     was_full_o;
  occ_t     occupancy_o;

  request_t   pending_requests[$];
  dq_result_t expected_results[$];

  word_t       ring_mem [DQ_DEPTH];
  int unsigned head_idx  = 0;
  int unsigned held_cnt  = 0;

  int unsigned request_total = 0;
  int unsigned sent_cnt      = 0;
  int unsigned recv_cnt      = 0;
  int unsigned failures      = 0;
  int unsigned send_gap      = 0;
  int unsigned send_calm     = 0;
  int unsigned recv_stall    = 0;
  int unsigned recv_calm     = 0;
  int unsigned hold_left     = 0;
  int unsigned idle_cycles   = 0;

  double_ended_queue #(
    .DEPTH      (DQ_DEPTH),
    .DATA_WIDTH (DQ_WIDTH)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .popped_value_o (popped_value_o),
    .was_empty_o    (was_empty_o),
    .was_full_o     (was_full_o),
    .occupancy_o    (occupancy_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void dq_apply(input op_code_t op, input word_t word);
    dq_result_t res;
    int unsigned kept;
    word_t held;
    res.popped = '0;
    res.empty  = 1'b0;
    res.full   = 1'b0;
    case (op)
      dq_pkg::OP_PUSH_BACK: begin
        if (held_cnt >= DQ_DEPTH) begin
          res.full = 1'b1;
        end else begin
          ring_mem[(head_idx + held_cnt) % DQ_DEPTH] = word;
          held_cnt++;
        end
      end
      dq_pkg::OP_POP_BACK: begin
        if (held_cnt == 0) begin
          res.empty  = 1'b1;
          res.popped = '1;
        end else begin
          held_cnt--;
          res.popped = ring_mem[(head_idx + held_cnt) % DQ_DEPTH];
        end
      end
      dq_pkg::OP_PUSH_FRONT: begin
        if (held_cnt >= DQ_DEPTH) begin
          res.full = 1'b1;
        end else begin
          head_idx = (head_idx + DQ_DEPTH - 1) % DQ_DEPTH;
          ring_mem[head_idx] = word;
          held_cnt++;
        end
      end
      dq_pkg::OP_POP_FRONT: begin
        if (held_cnt == 0) begin
          res.empty  = 1'b1;
          res.popped = '1;
        end else begin
          res.popped = ring_mem[head_idx];
          head_idx = (head_idx + 1) % DQ_DEPTH;
          held_cnt--;
        end
      end
      dq_pkg::OP_DELETE: begin
        kept = 0;
        for (int unsigned i = 0; i < held_cnt; i++) begin
          held = ring_mem[(head_idx + i) % DQ_DEPTH];
          if (held != word) begin
            ring_mem[(head_idx + kept) % DQ_DEPTH] = held;
            kept++;
          end
        end
        held_cnt = kept;
      end
      default: ;
    endcase
    res.occ = occ_t'(held_cnt);
    expected_results.push_back(res);
  endfunction

  function automatic int unsigned idle_len();
    if ($urandom_range(0, 1) == 0) return 0;
    if ($urandom_range(0, 11) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Bias toward a small set so that deletes find matches.
  function automatic word_t pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '1;
      3:       return '0;
      4, 5, 6: return word_t'($urandom_range(1, 6));
      default: return $urandom;
    endcase
  endfunction

  task automatic add_req(input op_code_t op, input word_t v);
    request_t req;
    req.op    = op;
    req.value = v;
    req.pause = 1'b0;
    pending_requests.push_back(req);
    request_total++;
  endtask

  task automatic add_pause();
    request_t req;
    req.op    = '0;
    req.value = '0;
    req.pause = 1'b1;
    pending_requests.push_back(req);
  endtask

  task automatic build_stimulus();
    phase_e      phase;
    int unsigned counted;
    int unsigned push_pct;
    int unsigned r;
    bit          first;
    add_req(dq_pkg::OP_POP_BACK, 32'sd5);
    add_req(dq_pkg::OP_POP_FRONT, 32'sd5);
    add_req(dq_pkg::OP_DELETE, '0);
    for (int c = OP_FIRST_UNUSED; c <= OP_LAST_UNUSED; c++) add_req(op_code_t'(c), '1);
    add_req(dq_pkg::OP_PUSH_BACK, 32'h7fff_ffff);
    add_req(dq_pkg::OP_PUSH_FRONT, 32'h8000_0000);
    add_req(dq_pkg::OP_PUSH_BACK, '1);
    add_req(dq_pkg::OP_PUSH_FRONT, '0);
    add_req(dq_pkg::OP_PUSH_BACK, 32'sd7);
    add_req(dq_pkg::OP_PUSH_FRONT, 32'sd7);
    add_req(dq_pkg::OP_PUSH_BACK, 32'sd7);
    add_req(dq_pkg::OP_DELETE, 32'sd7);
    add_req(dq_pkg::OP_DELETE, 32'sd99);
    add_req(dq_pkg::OP_POP_FRONT, '0);
    add_req(dq_pkg::OP_POP_BACK, '0);
    add_req(dq_pkg::OP_POP_FRONT, '0);
    add_req(dq_pkg::OP_POP_BACK, '0);
    add_req(dq_pkg::OP_POP_BACK, '0);
    add_pause();

    counted = 0;
    first   = 1'b1;
    while (counted < RANDOM_ITEMS) begin
      phase = first ? PH_FILL : phase_e'($urandom_range(0, 2));
      push_pct = (phase == PH_FILL) ? 85 : (phase == PH_DRAIN) ? 15 : 47;
      repeat ($urandom_range(20, 120)) begin
        r = $urandom_range(0, 99);
        if (first) begin
          add_req($urandom_range(0, 1) ? dq_pkg::OP_PUSH_BACK : dq_pkg::OP_PUSH_FRONT,
                  pick_value());
          counted++;
        end else if (r < 2) begin
          add_req(op_code_t'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED)), $urandom);
        end else if (r < 7) begin
          add_req(dq_pkg::OP_DELETE, pick_value());
          counted++;
        end else if ($urandom_range(0, 99) < push_pct) begin
          add_req($urandom_range(0, 1) ? dq_pkg::OP_PUSH_BACK : dq_pkg::OP_PUSH_FRONT,
                  pick_value());
          counted++;
        end else begin
          add_req($urandom_range(0, 1) ? dq_pkg::OP_POP_BACK : dq_pkg::OP_POP_FRONT,
                  pick_value());
          counted++;
        end
      end
      first = 1'b0;
      if ($urandom_range(0, 5) == 0) add_pause();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : drive
    request_t req;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      opcode_i   <= '0;
      value_i    <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        dq_apply(opcode_i, value_i);
        sent_cnt++;
      end
      if (send_calm > 0) begin
        send_calm--;
      end else if ($urandom_range(0, 299) == 0) begin
        send_calm = $urandom_range(60, 200);
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_requests.size() != 0 && !pending_requests[0].pause) begin
          req = pending_requests.pop_front();
          in_valid_i <= 1'b1;
          opcode_i   <= req.op;
          value_i    <= req.value;
          send_gap = (send_calm > 0) ? 0 : idle_len();
        end else begin
          in_valid_i <= 1'b0;
          // hold until every outstanding result is back
          if (pending_requests.size() != 0 && expected_results.size() == 0) begin
            void'(pending_requests.pop_front());
          end
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : watch
    dq_result_t exp_res;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        recv_cnt++;
        if (expected_results.size() == 0) begin
          $error("unexpected result transfer: popped_value %0d occupancy %0d",
                 popped_value_o, occupancy_o);
          failures++;
        end else begin
          exp_res = expected_results.pop_front();
          if (popped_value_o !== exp_res.popped) begin
            $error("popped_value: expected %0d, got %0d", exp_res.popped, popped_value_o);
            failures++;
          end
          if (was_empty_o !== exp_res.empty) begin
            $error("was_empty: expected %0b, got %0b", exp_res.empty, was_empty_o);
            failures++;
          end
          if (was_full_o !== exp_res.full) begin
            $error("was_full: expected %0b, got %0b", exp_res.full, was_full_o);
            failures++;
          end
          if (occupancy_o !== exp_res.occ) begin
            $error("occupancy: expected %0d, got %0d", exp_res.occ, occupancy_o);
            failures++;
          end
        end
        if (recv_cnt == HOLD_AT_RESULT) hold_left = LONG_HOLD;
      end
      if (recv_calm > 0) begin
        recv_calm--;
      end else if ($urandom_range(0, 299) == 0) begin
        recv_calm = $urandom_range(60, 200);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        recv_stall = (recv_calm > 0) ? 0 : idle_len();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  initial begin
    build_stimulus();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(negedge clk_i);
    while (sent_cnt != request_total || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      failures++;
    end
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
